### design/fwd_pkg.sv
// ----------------------------------------------------------------------------
// fwd_pkg
// Shared types, codes and helpers of the IPv4 forwarding decision block.
// ----------------------------------------------------------------------------
`default_nettype none

package fwd_pkg;

	// input item kinds (carried on tuser)
	localparam logic KIND_ROUTE = 1'b0;
	localparam logic KIND_HDR   = 1'b1;

	localparam logic [5:0] MAX_PREFIX_LEN = 6'd32;

	typedef enum logic [1:0] {
		ACT_LOCAL      = 2'd0,
		ACT_FORWARD    = 2'd1,
		ACT_DROP_TTL   = 2'd2,
		ACT_DROP_ROUTE = 2'd3
	} action_t;

	typedef enum logic {
		OP_ADD    = 1'b0,
		OP_LOOKUP = 1'b1
	} scan_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_EVAL,
		ST_LOOKUP,
		ST_EMIT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_SCAN,
		SC_WAIT,
		SC_FINISH
	} scan_state_t;

	typedef struct packed {
		logic [31:0] hop;
		logic [5:0]  len;
		logic [31:0] prefix;
	} route_entry_t;

	typedef struct packed {
		logic        start;
		scan_op_t    op;
		logic [31:0] prefix;
		logic [5:0]  len;
		logic [31:0] hop;
	} scan_req_t;

	typedef struct packed {
		logic        done;
		logic        found;
		logic [31:0] hop;
	} scan_rsp_t;

	typedef struct packed {
		logic [31:0] dest;
		logic [7:0]  ttl;
		logic [15:0] csum;
	} hdr_info_t;

	// network mask for a prefix length of 0 to 32
	function automatic logic [31:0] prefix_mask(input logic [5:0] len);
		logic [31:0] m;
		if (len == 6'd0) begin
			m = 32'h0000_0000;
		end else if (len >= MAX_PREFIX_LEN) begin
			m = 32'hffff_ffff;
		end else begin
			m = ~(32'hffff_ffff >> len);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

### design/fwd_ram.sv
// ----------------------------------------------------------------------------
// fwd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                       wr_data,
	input  wire logic                                   rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### design/fwd_hdr.sv
// ----------------------------------------------------------------------------
// fwd_hdr
// Header word tracker: word count, IHL, TTL and destination capture, and the
// ones' complement checksum accumulator with end-around carry.
// ----------------------------------------------------------------------------
`default_nettype none

module fwd_hdr (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               word_en,
	input  wire logic [31:0]        word,
	input  wire logic               last,
	output fwd_pkg::hdr_info_t      info
);

	logic [3:0]  word_count_q;
	logic [3:0]  ihl_q;
	logic [7:0]  ttl_q;
	logic [31:0] dest_q;
	logic [16:0] acc_q;

	logic [3:0]  ihl_eff;
	logic [16:0] acc_base;
	logic [16:0] acc_hi;
	logic [16:0] acc_two;
	logic [16:0] acc_ttl;
	logic [16:0] acc_d;
	logic [7:0]  ttl_dec;

	function automatic logic [16:0] add_half(input logic [16:0] acc, input logic [15:0] half);
		logic [17:0] s;
		s = {1'b0, acc} + {2'b00, half};
		if (s > 18'h0ffff) begin
			s = {2'b00, s[15:0]} + 18'd1;
		end
		return s[16:0];
	endfunction

	always_comb begin
		ihl_eff  = (word_count_q == 4'd0) ? word[27:24] : ihl_q;
		acc_base = (word_count_q == 4'd0) ? 17'd0 : acc_q;
		ttl_dec  = word[31:24] - 8'd1;
		acc_hi   = add_half(acc_base, word[31:16]);
		acc_two  = add_half(acc_hi, word[15:0]);
		// checksum half of word 2 is skipped, ttl enters already decremented
		acc_ttl  = add_half(acc_base, {ttl_dec, word[23:16]});
		if (word_count_q < ihl_eff) begin
			acc_d = (word_count_q == 4'd2) ? acc_ttl : acc_two;
		end else begin
			acc_d = acc_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= 4'd0;
			ihl_q        <= 4'd0;
			ttl_q        <= 8'd0;
			dest_q       <= 32'd0;
			acc_q        <= 17'd0;
		end else if (word_en) begin
			if (word_count_q == 4'd0) begin
				ihl_q  <= word[27:24];
				ttl_q  <= 8'd0;
				dest_q <= 32'd0;
			end
			if (word_count_q == 4'd2) begin
				ttl_q <= word[31:24];
			end
			if (word_count_q == 4'd4) begin
				dest_q <= word;
			end
			acc_q <= acc_d;
			if (last) begin
				word_count_q <= 4'd0;
			end else if (word_count_q != 4'hf) begin
				word_count_q <= word_count_q + 4'd1;
			end
		end
	end

	assign info.dest = dest_q;
	assign info.ttl  = ttl_q;
	assign info.csum = ~acc_q[15:0];

endmodule

`default_nettype wire

### design/fwd_scan.sv
// ----------------------------------------------------------------------------
// fwd_scan
// Route table sequencer: walks the table one entry per cycle through a single
// prefix compare unit, for route adds (duplicate and free slot search) and for
// longest-prefix lookups.
// ----------------------------------------------------------------------------
`default_nettype none

module fwd_scan #(
	parameter int ROUTE_ENTRIES = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fwd_pkg::scan_req_t req,
	output fwd_pkg::scan_rsp_t      rsp
);

	localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
	localparam int ENT_W = $bits(fwd_pkg::route_entry_t);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUTE_ENTRIES - 1);

	fwd_pkg::scan_state_t state_q, state_d;

	fwd_pkg::scan_op_t  op_q;
	logic [31:0]        key_prefix_q;
	logic [5:0]         key_len_q;
	logic [31:0]        key_hop_q;

	logic [IDX_W-1:0]   rd_idx_q;
	logic               cmp_vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [ROUTE_ENTRIES-1:0] valid_q;

	logic               best_found_q;
	logic [5:0]         best_len_q;
	logic [31:0]        best_hop_q;
	logic               dup_found_q;
	logic [IDX_W-1:0]   dup_idx_q;
	logic               free_found_q;
	logic [IDX_W-1:0]   free_idx_q;

	logic               rd_en;
	logic [ENT_W-1:0]   rd_data;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	fwd_pkg::route_entry_t wr_entry;
	fwd_pkg::route_entry_t entry;

	logic               ent_valid;
	logic [5:0]         cmp_len;
	logic               prefix_hit;
	logic               len_eq;
	logic               len_gt;
	logic               start;
	logic               finish;

	fwd_ram #(
		.WIDTH (ENT_W),
		.DEPTH (ROUTE_ENTRIES)
	) u_route_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	// shared compare unit
	always_comb begin
		entry      = fwd_pkg::route_entry_t'(rd_data);
		ent_valid  = valid_q[idx_s1];
		cmp_len    = (op_q == fwd_pkg::OP_ADD) ? key_len_q : entry.len;
		prefix_hit = (key_prefix_q & fwd_pkg::prefix_mask(cmp_len)) == entry.prefix;
		len_eq     = entry.len == key_len_q;
		len_gt     = entry.len > best_len_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fwd_pkg::SC_IDLE: begin
				if (req.start) begin
					state_d = fwd_pkg::SC_SCAN;
				end
			end
			fwd_pkg::SC_SCAN: begin
				if (rd_idx_q == LAST_IDX) begin
					state_d = fwd_pkg::SC_WAIT;
				end
			end
			fwd_pkg::SC_WAIT:   state_d = fwd_pkg::SC_FINISH;
			fwd_pkg::SC_FINISH: state_d = fwd_pkg::SC_IDLE;
			default:            state_d = fwd_pkg::SC_IDLE;
		endcase
	end

	always_comb begin
		start  = 1'b0;
		rd_en  = 1'b0;
		finish = 1'b0;
		unique case (state_q)
			fwd_pkg::SC_IDLE:   start  = req.start;
			fwd_pkg::SC_SCAN:   rd_en  = 1'b1;
			fwd_pkg::SC_WAIT:   finish = 1'b0;
			fwd_pkg::SC_FINISH: finish = 1'b1;
			default:            finish = 1'b0;
		endcase
		wr_en           = finish && (op_q == fwd_pkg::OP_ADD) && (dup_found_q || free_found_q);
		wr_addr         = dup_found_q ? dup_idx_q : free_idx_q;
		wr_entry.hop    = key_hop_q;
		wr_entry.len    = key_len_q;
		wr_entry.prefix = key_prefix_q;
		rsp.done        = finish;
		rsp.found       = best_found_q;
		rsp.hop         = best_hop_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fwd_pkg::SC_IDLE;
			cmp_vld_s1   <= 1'b0;
			rd_idx_q     <= '0;
			valid_q      <= '0;
			best_found_q <= 1'b0;
			dup_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= rd_en;
			if (start) begin
				rd_idx_q     <= '0;
				best_found_q <= 1'b0;
				dup_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
			if (cmp_vld_s1) begin
				if (op_q == fwd_pkg::OP_ADD) begin
					if (ent_valid && prefix_hit && len_eq) begin
						dup_found_q <= 1'b1;
					end
					if (!ent_valid && !free_found_q) begin
						free_found_q <= 1'b1;
					end
				end else if (ent_valid && prefix_hit && (!best_found_q || len_gt)) begin
					best_found_q <= 1'b1;
				end
			end
			if (finish && (op_q == fwd_pkg::OP_ADD) && !dup_found_q && free_found_q) begin
				valid_q[free_idx_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q         <= req.op;
			key_prefix_q <= req.prefix;
			key_len_q    <= req.len;
			key_hop_q    <= req.hop;
		end
		idx_s1 <= rd_idx_q;
		if (cmp_vld_s1) begin
			if (op_q == fwd_pkg::OP_ADD) begin
				if (ent_valid && prefix_hit && len_eq) begin
					dup_idx_q <= idx_s1;
				end
				if (!ent_valid && !free_found_q) begin
					free_idx_q <= idx_s1;
				end
			end else if (ent_valid && prefix_hit && (!best_found_q || len_gt)) begin
				best_len_q <= entry.len;
				best_hop_q <= entry.hop;
			end
		end
	end

endmodule

`default_nettype wire

### design/ipv4_forward_decision_top.sv
// ----------------------------------------------------------------------------
// ipv4_forward_decision_top
// IPv4 forwarding decision: route table adds, header word streaming with
// checksum update, and a local, ttl or longest-prefix verdict on the last word.
//
//  channel | dir | handshake          | content
//  s_*     | in  | s_tvalid/s_tready  | route add or header word
//  m_*     | out | m_tvalid/m_tready  | one verdict per header
//  cfg_*   | in  | cfg_valid/cfg_ready| local address
//
// a header word that is not the last leaves the block idle and ready for the
// next word; a route add runs through the one-entry-per-cycle table scan
// the last header word is judged in the eval state: a local or ttl verdict goes
// straight to emit, otherwise a longest-prefix lookup runs through the same scan
// s_tready is low while a route add or a verdict is in progress, and a verdict
// waits in its stage until the output register is free
// reset clears the route valid bits, the header state and the local address
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_forward_decision_top #(
	parameter int ROUTE_ENTRIES = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// config: local_address
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [31:0]  cfg_data,
	// slave side
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// header_word[31:0], route_dest[63:32], route_masklen[69:64],
	// route_nexthop[101:70], zero fill[103:102]
	input  wire logic [103:0] s_tdata,
	input  wire logic         s_tuser,   // kind
	input  wire logic         s_tlast,   // word_last
	// master side
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// next_hop[31:0], new_ttl[39:32], new_checksum[55:40]
	output logic [55:0]       m_tdata,
	output logic [1:0]        m_tuser    // action
);

	fwd_pkg::ctrl_state_t state_q, state_d;

	logic [31:0]        local_q;
	fwd_pkg::action_t   pend_action_q;
	logic [31:0]        pend_hop_q;
	logic               out_valid_q;
	fwd_pkg::action_t   out_action_q;
	logic [31:0]        out_hop_q;
	logic [7:0]         out_ttl_q;
	logic [15:0]        out_csum_q;

	logic               in_acc;
	logic               hdr_en;
	logic               route_acc;
	logic [5:0]         len_clamped;
	logic               out_free;
	logic               emit_load;
	logic               is_local;
	logic               ttl_zero;
	logic               fwd;

	fwd_pkg::hdr_info_t hdr;
	fwd_pkg::scan_req_t req;
	fwd_pkg::scan_rsp_t rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_q <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			local_q <= cfg_data;
		end
	end

	fwd_hdr u_hdr (
		.clk     (clk),
		.arst_n  (arst_n),
		.word_en (hdr_en),
		.word    (s_tdata[31:0]),
		.last    (s_tlast),
		.info    (hdr)
	);

	fwd_scan #(
		.ROUTE_ENTRIES (ROUTE_ENTRIES)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_comb begin
		in_acc      = s_tvalid && s_tready;
		hdr_en      = in_acc && (s_tuser == fwd_pkg::KIND_HDR);
		route_acc   = in_acc && (s_tuser == fwd_pkg::KIND_ROUTE);
		len_clamped = (s_tdata[69:64] > fwd_pkg::MAX_PREFIX_LEN) ?
			fwd_pkg::MAX_PREFIX_LEN : s_tdata[69:64];
		is_local    = hdr.dest == local_q;
		ttl_zero    = hdr.ttl == 8'd0;
		out_free    = !out_valid_q || m_tready;
		fwd         = pend_action_q == fwd_pkg::ACT_FORWARD;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fwd_pkg::ST_IDLE: begin
				if (route_acc) begin
					state_d = fwd_pkg::ST_ADD;
				end else if (hdr_en && s_tlast) begin
					state_d = fwd_pkg::ST_EVAL;
				end
			end
			fwd_pkg::ST_ADD: begin
				if (rsp.done) begin
					state_d = fwd_pkg::ST_IDLE;
				end
			end
			fwd_pkg::ST_EVAL: begin
				if (is_local || ttl_zero) begin
					state_d = fwd_pkg::ST_EMIT;
				end else begin
					state_d = fwd_pkg::ST_LOOKUP;
				end
			end
			fwd_pkg::ST_LOOKUP: begin
				if (rsp.done) begin
					state_d = fwd_pkg::ST_EMIT;
				end
			end
			fwd_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = fwd_pkg::ST_IDLE;
				end
			end
			default: state_d = fwd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		emit_load  = 1'b0;
		req.start  = 1'b0;
		req.op     = fwd_pkg::OP_ADD;
		req.prefix = s_tdata[63:32] & fwd_pkg::prefix_mask(len_clamped);
		req.len    = len_clamped;
		req.hop    = s_tdata[101:70];
		unique case (state_q)
			fwd_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				req.start = route_acc;
			end
			fwd_pkg::ST_EVAL: begin
				req.start  = !is_local && !ttl_zero;
				req.op     = fwd_pkg::OP_LOOKUP;
				req.prefix = hdr.dest;
			end
			fwd_pkg::ST_EMIT:   emit_load = out_free;
			fwd_pkg::ST_ADD:    emit_load = 1'b0;
			fwd_pkg::ST_LOOKUP: emit_load = 1'b0;
			default:            emit_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fwd_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fwd_pkg::ST_EVAL) begin
			pend_action_q <= is_local ? fwd_pkg::ACT_LOCAL : fwd_pkg::ACT_DROP_TTL;
		end else if ((state_q == fwd_pkg::ST_LOOKUP) && rsp.done) begin
			pend_action_q <= rsp.found ? fwd_pkg::ACT_FORWARD : fwd_pkg::ACT_DROP_ROUTE;
			pend_hop_q    <= rsp.hop;
		end
		if (emit_load) begin
			out_action_q <= pend_action_q;
			out_hop_q    <= fwd ? pend_hop_q : 32'd0;
			out_ttl_q    <= fwd ? (hdr.ttl - 8'd1) : 8'd0;
			out_csum_q   <= fwd ? hdr.csum : 16'd0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_csum_q, out_ttl_q, out_hop_q};
	assign m_tuser  = out_action_q;

endmodule

`default_nettype wire
